[src/lfuc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared types and constants of the LFU cache with LRU tie break.
// ----------------------------------------------------------------------------
package lfuc_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [KEY_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Write enables of the entry store for one cycle
    typedef struct packed {
        logic key_we;
        logic value_we;
        logic count_we;
        logic rank_we;
        logic valid_set;
        logic valid_clr;
    } t_wr_ctl;

    // What the current item does to the entries
    typedef struct packed {
        logic touch;
        logic insert;
        logic evict;
    } t_plan;

endpackage : lfuc_pkg
`default_nettype wire

[src/lfuc_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_in_if
// Request channel: one get or put per transfer.
// ----------------------------------------------------------------------------
interface lfuc_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface : lfuc_in_if
`default_nettype wire

[src/lfuc_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_out_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface lfuc_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface : lfuc_out_if
`default_nettype wire

[src/lfuc_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_store
// Entry store: key, value, use count and age rank memories with one
// registered read port and one write port, plus per-entry valid flops.
// ----------------------------------------------------------------------------
module lfuc_store
    import lfuc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16,
    parameter int IDX_W       = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [IDX_W-1:0]       i_rd_addr,
    output logic      [KEY_W-1:0]       o_rd_key,
    output logic      [KEY_W-1:0]       o_rd_value,
    output logic      [COUNT_BITS-1:0]  o_rd_count,
    output logic      [IDX_W-1:0]       o_rd_rank,
    input  wire t_wr_ctl                i_wr_ctl,
    input  wire logic [IDX_W-1:0]       i_wr_addr,
    input  wire logic [KEY_W-1:0]       i_wr_key,
    input  wire logic [KEY_W-1:0]       i_wr_value,
    input  wire logic [COUNT_BITS-1:0]  i_wr_count,
    input  wire logic [IDX_W-1:0]       i_wr_rank,
    input  wire logic [IDX_W-1:0]       i_clr_addr,
    output logic      [MAX_ENTRIES-1:0] o_valid
);

    logic [KEY_W-1:0]      mem_key   [MAX_ENTRIES];
    logic [KEY_W-1:0]      mem_value [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] mem_count [MAX_ENTRIES];
    logic [IDX_W-1:0]      mem_rank  [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] n_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.key_we)   mem_key[i_wr_addr]   <= i_wr_key;
        if (i_wr_ctl.value_we) mem_value[i_wr_addr] <= i_wr_value;
        if (i_wr_ctl.count_we) mem_count[i_wr_addr] <= i_wr_count;
        if (i_wr_ctl.rank_we)  mem_rank[i_wr_addr]  <= i_wr_rank;
        o_rd_key   <= mem_key[i_rd_addr];
        o_rd_value <= mem_value[i_rd_addr];
        o_rd_count <= mem_count[i_rd_addr];
        o_rd_rank  <= mem_rank[i_rd_addr];
    end

    // Clear before set: when the victim's slot is reused the set wins
    always_comb begin
        n_valid = r_valid;
        if (i_wr_ctl.valid_clr) n_valid[i_clr_addr] = 1'b0;
        if (i_wr_ctl.valid_set) n_valid[i_wr_addr]  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule : lfuc_store
`default_nettype wire

[src/lfuc_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfuc_unit
// Shared per-entry unit: during the search pass it compares one entry a cycle
// for key match, eviction victim and first free slot; during the update pass
// it works out the new age rank of one entry a cycle.
// ----------------------------------------------------------------------------
module lfuc_unit
    import lfuc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire logic                  i_scan,
    input  wire logic [KEY_W-1:0]      i_key,
    input  wire logic [IDX_W-1:0]      i_idx,
    input  wire logic                  i_ent_valid,
    input  wire logic [KEY_W-1:0]      i_ent_key,
    input  wire logic [KEY_W-1:0]      i_ent_value,
    input  wire logic [COUNT_BITS-1:0] i_ent_count,
    input  wire logic [IDX_W-1:0]      i_ent_rank,
    input  wire t_plan                 i_plan,
    output logic                       o_hit,
    output logic      [IDX_W-1:0]      o_hit_idx,
    output logic      [KEY_W-1:0]      o_hit_value,
    output logic      [COUNT_BITS-1:0] o_hit_count,
    output logic      [IDX_W-1:0]      o_vic_idx,
    output logic      [KEY_W-1:0]      o_vic_key,
    output logic                       o_free_found,
    output logic      [IDX_W-1:0]      o_free_idx,
    output logic                       o_rank_we,
    output logic      [IDX_W-1:0]      o_new_rank
);

    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [KEY_W-1:0]      r_hit_value;
    logic [COUNT_BITS-1:0] r_hit_count;
    logic [IDX_W-1:0]      r_hit_rank;
    logic                  r_vic_found;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [KEY_W-1:0]      r_vic_key;
    logic [COUNT_BITS-1:0] r_vic_count;
    logic [IDX_W-1:0]      r_vic_rank;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;

    logic w_match;
    logic w_better;

    assign w_match  = i_ent_valid && (i_ent_key == i_key) && !r_hit;
    assign w_better = i_ent_valid && (!r_vic_found || (i_ent_count < r_vic_count) ||
                      ((i_ent_count == r_vic_count) && (i_ent_rank > r_vic_rank)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_clear) begin
            r_hit        <= 1'b0;
            r_vic_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_scan) begin
            if (w_match)                     r_hit        <= 1'b1;
            if (w_better)                    r_vic_found  <= 1'b1;
            if (!i_ent_valid && !r_free_found) r_free_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan) begin
            if (w_match) begin
                r_hit_idx   <= i_idx;
                r_hit_value <= i_ent_value;
                r_hit_count <= i_ent_count;
                r_hit_rank  <= i_ent_rank;
            end
            if (w_better) begin
                r_vic_idx   <= i_idx;
                r_vic_key   <= i_ent_key;
                r_vic_count <= i_ent_count;
                r_vic_rank  <= i_ent_rank;
            end
            if (!i_ent_valid && !r_free_found) r_free_idx <= i_idx;
        end
    end

    // Rank update of one entry; the touched or inserted entry is written later
    always_comb begin
        o_rank_we  = 1'b0;
        o_new_rank = i_ent_rank;
        if (i_ent_valid) begin
            if (i_plan.touch) begin
                if ((i_idx != r_hit_idx) && (i_ent_rank < r_hit_rank)) begin
                    o_rank_we  = 1'b1;
                    o_new_rank = i_ent_rank + IDX_W'(1);
                end
            end else if (i_plan.insert) begin
                if (!(i_plan.evict && (i_idx == r_vic_idx))) begin
                    o_rank_we = 1'b1;
                    if (i_plan.evict && (i_ent_rank > r_vic_rank)) begin
                        o_new_rank = i_ent_rank;
                    end else begin
                        o_new_rank = i_ent_rank + IDX_W'(1);
                    end
                end
            end
        end
    end

    assign o_hit        = r_hit;
    assign o_hit_idx    = r_hit_idx;
    assign o_hit_value  = r_hit_value;
    assign o_hit_count  = r_hit_count;
    assign o_vic_idx    = r_vic_idx;
    assign o_vic_key    = r_vic_key;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;

endmodule : lfuc_unit
`default_nettype wire

[src/lfu_cache_with_lru_tiebreak.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak
// Key-value cache, least-frequently-used replacement, oldest first on ties.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries a get (action 0) or put (action 1) of a 32-bit key and value;
//   o_rsp returns one result per request: hit, read value (-1 on a miss and
//   for puts), and the key of any entry evicted by a put.
//   i_cfg_we / i_cfg_data write the capacity; write it only while idle.
// Sequence:
//   Two passes over the one-read-port store, one entry a cycle: search for key,
//   victim and free slot, then rank update; the rank update pass is skipped when
//   nothing changes (get miss, put at capacity zero). i_req.ready is high only in
//   idle, so no new request is taken until the last result is in the output register.
// Reset: all entries become invalid at once, capacity returns to 16.
// Stall:
//   The result sits in an output register; a new request may be taken while
//   it waits, and its own result is held back until the old one transfers.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak
    import lfuc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_data,
    lfuc_in_if.sink               i_req,
    lfuc_out_if.source            o_rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0] r_live;
    logic [CNT_W-1:0] r_idx;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic             r_action;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_value;
    t_plan            r_plan;
    t_plan            n_plan;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] n_slot;

    logic             r_out_valid;
    logic             r_out_hit;
    logic [KEY_W-1:0] r_out_read_value;
    logic             r_out_evicted;
    logic [KEY_W-1:0] r_out_evicted_key;

    logic                   w_accept;
    logic                   w_issue;
    logic                   w_pass_done;
    logic                   w_fin_go;
    logic [CNT_W-1:0]       w_cap;
    logic [MAX_ENTRIES-1:0] w_valid;
    logic                   w_ent_valid;

    logic [KEY_W-1:0]      w_rd_key;
    logic [KEY_W-1:0]      w_rd_value;
    logic [COUNT_BITS-1:0] w_rd_count;
    logic [IDX_W-1:0]      w_rd_rank;

    t_wr_ctl               w_wr_ctl;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [KEY_W-1:0]      w_wr_value;
    logic [COUNT_BITS-1:0] w_wr_count;
    logic [IDX_W-1:0]      w_wr_rank;

    logic                  u_hit;
    logic [IDX_W-1:0]      u_hit_idx;
    logic [KEY_W-1:0]      u_hit_value;
    logic [COUNT_BITS-1:0] u_hit_count;
    logic [IDX_W-1:0]      u_vic_idx;
    logic [KEY_W-1:0]      u_vic_key;
    logic                  u_free_found;
    logic [IDX_W-1:0]      u_free_idx;
    logic                  u_rank_we;
    logic [IDX_W-1:0]      u_new_rank;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_issue     = ((r_state == S_SCAN) || (r_state == S_UPD)) &&
                         (r_idx != CNT_W'(MAX_ENTRIES));
    assign w_pass_done = !w_issue && !r_pv;
    assign w_fin_go    = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);
    assign w_ent_valid = w_valid[r_pidx];

    // Capacity above the entry count acts as the entry count
    always_comb begin
        if (32'(r_capacity) > 32'(MAX_ENTRIES)) begin
            w_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            w_cap = CNT_W'(r_capacity);
        end
    end

    // Plan the changes once the search pass is through
    always_comb begin
        n_plan.touch  = u_hit && ((r_action == ACT_GET) || (w_cap != '0));
        n_plan.insert = (r_action == ACT_PUT) && !u_hit && (w_cap != '0);
        n_plan.evict  = n_plan.insert && (r_live >= w_cap);
        if (n_plan.evict) begin
            if (u_free_found && (u_free_idx < u_vic_idx)) begin
                n_slot = u_free_idx;
            end else begin
                n_slot = u_vic_idx;
            end
        end else if (n_plan.insert) begin
            n_slot = u_free_idx;
        end else begin
            n_slot = u_hit_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (w_pass_done) n_state = S_DECIDE;
            S_DECIDE: begin
                if (n_plan.touch || n_plan.insert) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_UPD:    if (w_pass_done) n_state = S_FIN;
            S_FIN:    if (w_fin_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_capacity <= CAP_RESET;
            r_live     <= '0;
            r_idx      <= '0;
            r_pv       <= 1'b0;
            r_plan     <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= w_issue;
            if (i_cfg_we) r_capacity <= i_cfg_data;
            if (w_accept || (r_state == S_DECIDE)) begin
                r_idx <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_state == S_DECIDE) r_plan <= n_plan;
            if (w_fin_go && r_plan.insert && !r_plan.evict) r_live <= r_live + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[IDX_W-1:0];
        if (w_accept) begin
            r_action <= i_req.action;
            r_key    <= i_req.key;
            r_value  <= i_req.value;
        end
        if (r_state == S_DECIDE) r_slot <= n_slot;
    end

    // Store writes: rank sweep during the update pass, target entry at the end
    always_comb begin
        w_wr_ctl   = '0;
        w_wr_addr  = r_pidx;
        w_wr_value = r_value;
        w_wr_count = COUNT_BITS'(1);
        w_wr_rank  = u_new_rank;
        if (r_state == S_UPD) begin
            w_wr_ctl.rank_we = r_pv && u_rank_we;
        end else if (w_fin_go) begin
            w_wr_addr = r_slot;
            w_wr_rank = '0;
            if (r_plan.insert) begin
                w_wr_ctl.key_we    = 1'b1;
                w_wr_ctl.value_we  = 1'b1;
                w_wr_ctl.count_we  = 1'b1;
                w_wr_ctl.rank_we   = 1'b1;
                w_wr_ctl.valid_set = 1'b1;
                w_wr_ctl.valid_clr = r_plan.evict && (r_slot != u_vic_idx);
            end else if (r_plan.touch) begin
                w_wr_ctl.value_we = (r_action == ACT_PUT);
                w_wr_ctl.count_we = 1'b1;
                w_wr_ctl.rank_we  = 1'b1;
                // Saturate at the count maximum
                if (u_hit_count != '1) begin
                    w_wr_count = u_hit_count + COUNT_BITS'(1);
                end else begin
                    w_wr_count = u_hit_count;
                end
            end
        end
    end

    lfuc_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COUNT_BITS  (COUNT_BITS),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_idx[IDX_W-1:0]),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value),
        .o_rd_count (w_rd_count),
        .o_rd_rank  (w_rd_rank),
        .i_wr_ctl   (w_wr_ctl),
        .i_wr_addr  (w_wr_addr),
        .i_wr_key   (r_key),
        .i_wr_value (w_wr_value),
        .i_wr_count (w_wr_count),
        .i_wr_rank  (w_wr_rank),
        .i_clr_addr (u_vic_idx),
        .o_valid    (w_valid)
    );

    lfuc_unit #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_unit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_accept),
        .i_scan       ((r_state == S_SCAN) && r_pv),
        .i_key        (r_key),
        .i_idx        (r_pidx),
        .i_ent_valid  (w_ent_valid),
        .i_ent_key    (w_rd_key),
        .i_ent_value  (w_rd_value),
        .i_ent_count  (w_rd_count),
        .i_ent_rank   (w_rd_rank),
        .i_plan       (r_plan),
        .o_hit        (u_hit),
        .o_hit_idx    (u_hit_idx),
        .o_hit_value  (u_hit_value),
        .o_hit_count  (u_hit_count),
        .o_vic_idx    (u_vic_idx),
        .o_vic_key    (u_vic_key),
        .o_free_found (u_free_found),
        .o_free_idx   (u_free_idx),
        .o_rank_we    (u_rank_we),
        .o_new_rank   (u_new_rank)
    );

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out_hit     <= u_hit;
            r_out_evicted <= r_plan.evict;
            if ((r_action == ACT_GET) && u_hit) begin
                r_out_read_value <= u_hit_value;
            end else begin
                r_out_read_value <= MISS_VALUE;
            end
            if (r_plan.evict) begin
                r_out_evicted_key <= u_vic_key;
            end else begin
                r_out_evicted_key <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_read_value;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_evicted_key;

`ifndef SYNTHESIS
    a_live_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_live))
        else $error("live count out of step with valid entries");

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_live) <= MAX_ENTRIES)
        else $error("live count above entry count");

    a_evict_is_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_evicted) |-> (!r_out_hit && (r_out_read_value == MISS_VALUE)))
        else $error("eviction reported on a hit or a get");

    a_no_evict_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_evicted) |-> (r_out_evicted_key == '0))
        else $error("evicted key set without an eviction");

    a_insert_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && r_plan.insert) |->
        (!w_valid[r_slot] || (r_plan.evict && (r_slot == u_vic_idx))))
        else $error("insert into an occupied entry");
`endif

endmodule : lfu_cache_with_lru_tiebreak
`default_nettype wire
